[design/bcr_pkg.sv]
package bcr_pkg;

  // Sample format: signed Q1.(SAMPLE_W-1)
  localparam int unsigned SAMPLE_W  = 16;

  // Register field widths
  localparam int unsigned FACTOR_W  = 13;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned INV_W     = 17;
  localparam int unsigned GAIN_W    = 12;

  // Decimator limits, unsigned Q5.8
  localparam logic [FACTOR_W-1:0] FACTOR_MIN = FACTOR_W'(256);
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = FACTOR_W'(4096);
  localparam logic [FACTOR_W-1:0] COUNT_STEP = FACTOR_W'(256);

  // Shared multiplier: signed MUL_W x signed MUL_W
  localparam int unsigned MUL_W     = SCALE_W + 1;
  localparam int unsigned PROD_W    = 2 * MUL_W;

  // Reduce stage: q = (s * scale) >>> RED_SHIFT, then (q * inv) >>> RED_POST
  localparam int unsigned RED_SHIFT = SAMPLE_W + 7;
  localparam int unsigned Q_W       = SAMPLE_W + 1;
  localparam int unsigned RED_POST  = 17 - SAMPLE_W;
  localparam int unsigned CLIP_SHIFT = 8;

  localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) << (SAMPLE_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) << (SAMPLE_W - 1));

  // Register map indexes
  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_FACTOR    = 3'd1,
    REG_REDUCE_ON = 3'd2,
    REG_SCALE     = 3'd3,
    REG_INVERSE   = 3'd4,
    REG_CLIP_ON   = 3'd5,
    REG_GAIN      = 3'd6,
    REG_NONE      = 3'd7
  } bcr_reg_e;

  typedef struct packed {
    logic                enable;
    logic [FACTOR_W-1:0] decimate_factor;
    logic                reduce_on;
    logic [SCALE_W-1:0]  reduce_scale;
    logic [INV_W-1:0]    reduce_inverse;
    logic                clip_on;
    logic [GAIN_W-1:0]   clip_gain;
  } bcr_cfg_t;

  // One queued item: bypass marks a pass-through sample
  typedef struct packed {
    logic                       bypass;
    logic signed [SAMPLE_W-1:0] sample;
  } bcr_item_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/bcr_front.sv]
module bcr_front
  import bcr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcr_cfg_t                   cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output bcr_item_t                  q_item_o
);

  logic [FACTOR_W-1:0]        count_q, count_d;
  logic signed [SAMPLE_W-1:0] held_q, held_d;
  logic [FACTOR_W-1:0]        factor;
  logic [FACTOR_W-1:0]        count_inc;
  logic                       capture;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    priority if (cfg_i.decimate_factor < FACTOR_MIN) begin
      factor = FACTOR_MIN;
    end else if (cfg_i.decimate_factor > FACTOR_MAX) begin
      factor = FACTOR_MAX;
    end else begin
      factor = cfg_i.decimate_factor;
    end
  end

  assign count_inc = count_q + COUNT_STEP;
  assign capture   = (count_inc >= factor);

  always_comb begin
    count_d         = count_q;
    held_d          = held_q;
    q_item_o.bypass = !cfg_i.enable;
    q_item_o.sample = in_sample_i;
    if (cfg_i.enable) begin
      // one subtraction per sample, even if the count stays above the factor
      count_d = capture ? (count_inc - factor) : count_inc;
      held_d  = capture ? in_sample_i : held_q;
      q_item_o.sample = held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      held_q  <= '0;
    end else if (q_push_o) begin
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

endmodule

[design/bcr_fifo.sv]
module bcr_fifo
  import bcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bcr_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output bcr_item_t item_o
);

  localparam int unsigned DEPTH = 2;

  bcr_item_t  mem_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(DEPTH));
  assign empty_o = (count_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/bcr_back.sv]
module bcr_back
  import bcr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcr_cfg_t                   cfg_i,
  input  logic                       q_empty_i,
  input  bcr_item_t                  q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_MUL2 = 7'b0000100,
    ST_RSAT = 7'b0001000,
    ST_MUL3 = 7'b0010000,
    ST_CSAT = 7'b0100000,
    ST_DONE = 7'b1000000
  } bcr_state_e;

  bcr_state_e                 state_q, state_d;
  logic signed [SAMPLE_W-1:0] v_q, v_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [Q_W-1:0]      quant;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_free;
  logic                       load_out;

  assign quant    = prod_q[RED_SHIFT+Q_W-1:RED_SHIFT];
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign load_out = (state_q == ST_DONE) && out_free;

  // Shared multiplier operand select
  always_comb begin
    mul_a = MUL_W'(v_q);
    mul_b = $signed({1'b0, cfg_i.reduce_scale});
    unique case (state_q)
      ST_MUL2: begin
        mul_a = MUL_W'(quant);
        mul_b = $signed(MUL_W'(cfg_i.reduce_inverse));
      end
      ST_MUL3: begin
        mul_b = $signed(MUL_W'(cfg_i.clip_gain));
      end
      default: begin
        mul_a = MUL_W'(v_q);
        mul_b = $signed({1'b0, cfg_i.reduce_scale});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          v_d = q_item_i.sample;
          priority if (q_item_i.bypass) begin
            state_d = ST_DONE;
          end else if (cfg_i.reduce_on) begin
            state_d = ST_MUL1;
          end else if (cfg_i.clip_on) begin
            state_d = ST_MUL3;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_RSAT;
      ST_RSAT: begin
        v_d     = sat_sample(prod_q >>> RED_POST);
        state_d = cfg_i.clip_on ? ST_MUL3 : ST_DONE;
      end
      ST_MUL3: state_d = ST_CSAT;
      ST_CSAT: begin
        v_d     = sat_sample(prod_q >>> CLIP_SHIFT);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_MUL3) begin
      prod_q <= mul_p;
    end
    if (load_out) begin
      out_q <= v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule

[design/audio_bitcrusher.sv]
// Audio bitcrusher: sample-rate and bit-depth reducer with drive clipping.
//
// Input stream (s_axis_*) carries one signed Q1.15 sample per item; the
// output stream (m_axis_*) returns exactly one processed sample per item,
// in order. Configuration goes through the APB-style port; write registers
// only while no item is in flight.
//
// The front end runs the sample-and-hold decimator as each item is taken and
// drops the result into a two-entry queue. The back end drains the queue
// through one shared 25x25 multiplier: reduce takes two products, clip one,
// each followed by a shift-and-saturate step.
// With both stages off or the block disabled, an item goes from the queue
// through the idle and done states into the output register; reduce adds
// the MUL1, MUL2 and RSAT states, clip the MUL3 and CSAT states. The back
// end pops a new item only after loading its last one for output, which
// sets the sustained rate. Reset clears the hold counter, the held sample,
// the queue and the output valid flag, and loads the register defaults.
// When the receiver stalls, the output register holds its item, the back
// end waits, the queue fills and s_axis_tready falls.
module audio_bitcrusher
  import bcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] sample_in
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [15:0] sample_out
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  bcr_cfg_t  cfg_q;
  bcr_reg_e  reg_idx;
  logic      cfg_we;

  bcr_item_t front_item, queue_item;
  logic      q_push, q_pop, q_full, q_empty;
  logic signed [SAMPLE_W-1:0] out_sample;

  // Register file: index by word address, ignore writes past the list
  assign pready  = 1'b1;
  assign reg_idx = bcr_reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable          <= 1'b1;
      cfg_q.decimate_factor <= FACTOR_W'(256);
      cfg_q.reduce_on       <= 1'b0;
      cfg_q.reduce_scale    <= SCALE_W'(8388608);
      cfg_q.reduce_inverse  <= INV_W'(2);
      cfg_q.clip_on         <= 1'b0;
      cfg_q.clip_gain       <= GAIN_W'(256);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_ENABLE:    cfg_q.enable          <= pwdata[0];
        REG_FACTOR:    cfg_q.decimate_factor <= pwdata[FACTOR_W-1:0];
        REG_REDUCE_ON: cfg_q.reduce_on       <= pwdata[0];
        REG_SCALE:     cfg_q.reduce_scale    <= pwdata[SCALE_W-1:0];
        REG_INVERSE:   cfg_q.reduce_inverse  <= pwdata[INV_W-1:0];
        REG_CLIP_ON:   cfg_q.clip_on         <= pwdata[0];
        REG_GAIN:      cfg_q.clip_gain       <= pwdata[GAIN_W-1:0];
        default:       cfg_q                 <= cfg_q;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:    prdata = 32'(cfg_q.enable);
      REG_FACTOR:    prdata = 32'(cfg_q.decimate_factor);
      REG_REDUCE_ON: prdata = 32'(cfg_q.reduce_on);
      REG_SCALE:     prdata = 32'(cfg_q.reduce_scale);
      REG_INVERSE:   prdata = 32'(cfg_q.reduce_inverse);
      REG_CLIP_ON:   prdata = 32'(cfg_q.clip_on);
      REG_GAIN:      prdata = 32'(cfg_q.clip_gain);
      default:       prdata = '0;
    endcase
  end

  // Front end: accept, run the decimator, queue the item
  bcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i ($signed(s_axis_tdata)),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (front_item)
  );

  // Decouple front from back so each can stall on its own
  bcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (queue_item)
  );

  // Back end: reduce and clip on the shared multiplier, hold the result
  bcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_item_i     (queue_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample)
  );

  assign m_axis_tdata = out_sample;

endmodule
